/* sv/lat_pkg.sv */
// Shared constants and field layouts of the logic-analyser trigger capture block.
package lat_pkg;

  localparam int TIME_W     = 64;
  localparam int LEV_W      = 8;
  localparam int CH_W       = 3;
  localparam int FUNC_W     = 2;
  localparam int ENTRY_W    = TIME_W + LEV_W;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CNT_W      = 24;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 3;

  localparam int RING_DEPTH_DEF = 32;
  localparam int CHANNELS       = 8;
  localparam logic [LEV_W-1:0] CHAN_MASK = LEV_W'((9'd1 << CHANNELS) - 9'd1);

  localparam logic [CFG_IDX_W-1:0] REG_TRIG_TYPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_CHAN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COND_EN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COND_CHAN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COND_LEVEL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POST_LIMIT = 3'd5;

  localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EVENT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd2;

  localparam logic [1:0] TRIG_NONE    = 2'd0;
  localparam logic [1:0] TRIG_RISING  = 2'd1;
  localparam logic [1:0] TRIG_FALLING = 2'd2;
  localparam logic [1:0] TRIG_ANY     = 2'd3;

  localparam logic [1:0] LEVEL_LOW     = 2'd0;
  localparam logic [1:0] LEVEL_HIGH    = 2'd1;
  localparam logic [1:0] LEVEL_UNKNOWN = 2'd2;

  localparam logic [CNT_W-1:0] COUNT_MAX = 24'hFFFFFF;

  localparam int TUSER_PRE  = 0;
  localparam int TUSER_TRIG = 1;
  localparam int TUSER_DONE = 2;

endpackage

/* sv/lat_cell.sv */
// One stage of the pre-trigger shift chain, holding a single timestamped record.
module lat_cell #(
  parameter int WIDTH = lat_pkg::ENTRY_W
) (
  input  logic             clk,
  input  logic             shift,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] entry;

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= d;
    end
  end

  assign q = entry;

endmodule

/* sv/logic_analyzer_trigger_capture_top.sv */
// Top level of the logic-analyser trigger capture block with its pre-trigger chain.
//
//  Channel  Direction  Transfer when              Payload
//  s_*      in         s_tvalid && s_tready       command, channel, timestamp, levels
//  m_*      out        m_tvalid && m_tready       record timestamp, levels, flags
//  cfg_*    in         cfg_we                     register index and value
//
// An event accepted after the trigger, before the post-trigger limit halts capture, puts
// its record into the output register.
// A stop after the trigger with records in the ring walks the shift chain through all
// RING_DEPTH stages, one stage per cycle while the output is not stalled, and emits the
// stored records oldest first in the last fill steps of that walk.
// A stalled output holds the block, and no command is taken during the flush walk.
// Reset is synchronous; the record chain itself is not cleared.
module logic_analyzer_trigger_capture_top #(
  parameter int RING_DEPTH = lat_pkg::RING_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // event_channel [2:0], event_time [66:3], channel_levels [74:67], zero fill above
  input  logic [lat_pkg::IN_TDATA_W-1:0]   s_tdata,
  // func [1:0]
  input  logic [lat_pkg::FUNC_W-1:0]       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // record_time [63:0], record_levels [71:64]
  output logic [lat_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // from_pretrigger [0], triggered_flag [1], done_flag [2]
  output logic [lat_pkg::OUT_TUSER_W-1:0]  m_tuser,
  output logic                             m_tlast,
  input  logic                             cfg_we,
  input  logic [lat_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lat_pkg::CFG_W-1:0]        cfg_data
);

  localparam int FILL_W = $clog2(RING_DEPTH + 1);
  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic [1:0]                 trig_type;
  logic [lat_pkg::CH_W-1:0]   trig_chan;
  logic                       cond_en;
  logic [lat_pkg::CH_W-1:0]   cond_chan;
  logic                       cond_match;
  logic [lat_pkg::CNT_W-1:0]  post_limit;

  logic                       state;
  logic                       capturing;
  logic                       fired;
  logic                       finished;
  logic                       halted;
  logic [1:0]                 prev_level;
  logic [FILL_W-1:0]          fill;
  logic [FILL_W-1:0]          step;
  logic [lat_pkg::CNT_W-1:0]  post_count;

  logic                                oval;
  logic [lat_pkg::OUT_TDATA_W-1:0]     odata;
  logic [lat_pkg::OUT_TUSER_W-1:0]     ouser;
  logic                                olast;

  logic [lat_pkg::FUNC_W-1:0] func;
  logic [lat_pkg::CH_W-1:0]   ev_chan;
  logic [lat_pkg::TIME_W-1:0] ev_time;
  logic [lat_pkg::LEV_W-1:0]  ev_lev;
  logic                       out_free;
  logic                       accept;
  logic                       ev_live;
  logic                       store;
  logic                       post_emit;
  logic                       flush_step;
  logic                       flush_emit;
  logic                       flush_end;
  logic                       cur;
  logic                       edge_hit;
  logic                       cond_ok;
  logic [lat_pkg::CNT_W-1:0]  post_count_next;
  logic                       shift;
  logic [lat_pkg::ENTRY_W-1:0] chain_q [RING_DEPTH];

  assign func    = s_tuser;
  assign ev_chan = s_tdata[2:0];
  assign ev_time = s_tdata[66:3];
  assign ev_lev  = s_tdata[74:67] & lat_pkg::CHAN_MASK;

  assign out_free = !oval || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  assign ev_live   = accept && (func == lat_pkg::FUNC_EVENT) && capturing && !halted
                     && (32'(ev_chan) < lat_pkg::CHANNELS);
  assign store     = ev_live && !fired;
  assign post_emit = ev_live && fired;

  assign cur      = ev_lev[ev_chan];
  assign edge_hit = ((trig_type == lat_pkg::TRIG_RISING) && cur
                     && (prev_level == lat_pkg::LEVEL_LOW))
                 || ((trig_type == lat_pkg::TRIG_FALLING) && !cur
                     && (prev_level == lat_pkg::LEVEL_HIGH))
                 || ((trig_type == lat_pkg::TRIG_ANY) && ({1'b0, cur} != prev_level));
  assign cond_ok  = !cond_en || (ev_lev[cond_chan] == cond_match);

  assign post_count_next = (post_count == lat_pkg::COUNT_MAX) ? post_count
                                                                : post_count + 1'b1;

  assign flush_step = (state == ST_FLUSH) && out_free;
  assign flush_emit = ({1'b0, step} + {1'b0, fill}) >= (FILL_W + 1)'(RING_DEPTH);
  assign flush_end  = step == FILL_W'(RING_DEPTH - 1);

  assign shift = store || flush_step;

  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_chain
    if (i == 0) begin : g_head
      lat_cell #(.WIDTH(lat_pkg::ENTRY_W)) u_cell (
        .clk   (clk),
        .shift (shift),
        .d     ({ev_lev, ev_time}),
        .q     (chain_q[i])
      );
    end else begin : g_body
      lat_cell #(.WIDTH(lat_pkg::ENTRY_W)) u_cell (
        .clk   (clk),
        .shift (shift),
        .d     (chain_q[i-1]),
        .q     (chain_q[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_type  <= lat_pkg::TRIG_NONE;
      trig_chan  <= '0;
      cond_en    <= 1'b0;
      cond_chan  <= '0;
      cond_match <= 1'b0;
      post_limit <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lat_pkg::REG_TRIG_TYPE:  trig_type  <= cfg_data[1:0];
        lat_pkg::REG_TRIG_CHAN:  trig_chan  <= cfg_data[2:0];
        lat_pkg::REG_COND_EN:    cond_en    <= cfg_data[0];
        lat_pkg::REG_COND_CHAN:  cond_chan  <= cfg_data[2:0];
        lat_pkg::REG_COND_LEVEL: cond_match <= cfg_data[0];
        lat_pkg::REG_POST_LIMIT: post_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      capturing  <= 1'b0;
      fired      <= 1'b0;
      finished   <= 1'b0;
      halted     <= 1'b0;
      prev_level <= lat_pkg::LEVEL_UNKNOWN;
      fill       <= '0;
      step       <= '0;
      post_count <= '0;
      oval       <= 1'b0;
    end else begin
      if (out_free) begin
        oval <= post_emit || (flush_step && flush_emit);
      end
      if (accept) begin
        case (func)
          lat_pkg::FUNC_START: begin
            capturing  <= 1'b1;
            fired      <= (trig_type == lat_pkg::TRIG_NONE);
            finished   <= (trig_type == lat_pkg::TRIG_NONE);
            halted     <= 1'b0;
            prev_level <= lat_pkg::LEVEL_UNKNOWN;
            fill       <= '0;
            post_count <= '0;
          end
          lat_pkg::FUNC_EVENT: begin
            if (store) begin
              if (fill != FILL_W'(RING_DEPTH)) begin
                fill <= fill + 1'b1;
              end
              if (ev_chan == trig_chan) begin
                prev_level <= {1'b0, cur};
                if (edge_hit && cond_ok) begin
                  fired      <= 1'b1;
                  post_count <= '0;
                end
              end
            end else if (post_emit) begin
              post_count <= post_count_next;
              if (post_count_next >= post_limit) begin
                finished <= 1'b1;
                halted   <= 1'b1;
              end
            end
          end
          lat_pkg::FUNC_STOP: begin
            if (capturing) begin
              capturing <= 1'b0;
              if (fired && (fill != '0)) begin
                state <= ST_FLUSH;
                step  <= '0;
              end
            end
          end
          default: ;
        endcase
      end
      if (flush_step) begin
        step <= step + 1'b1;
        if (flush_end) begin
          state <= ST_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (post_emit && out_free) begin
      odata                      <= {ev_lev, ev_time};
      olast                      <= 1'b1;
      ouser[lat_pkg::TUSER_PRE]  <= 1'b0;
      ouser[lat_pkg::TUSER_TRIG] <= 1'b1;
      ouser[lat_pkg::TUSER_DONE] <= finished || (post_count_next >= post_limit);
    end else if (flush_step) begin
      odata                      <= chain_q[RING_DEPTH-1];
      olast                      <= flush_end;
      ouser[lat_pkg::TUSER_PRE]  <= 1'b1;
      ouser[lat_pkg::TUSER_TRIG] <= fired;
      ouser[lat_pkg::TUSER_DONE] <= finished;
    end
  end

  assign m_tvalid = oval;
  assign m_tdata  = odata;
  assign m_tuser  = ouser;
  assign m_tlast  = olast;

endmodule

/* sv/lat_checker.sv */
// Port-level checker for the logic-analyser trigger capture block and its binding.
module lat_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [lat_pkg::OUT_TUSER_W-1:0] m_tuser,
  input logic                            m_tlast
);

  // A record waiting for its transfer stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output record withdrawn before its transfer");

  // A post-trigger record always closes the results of its event.
  a_post_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[lat_pkg::TUSER_PRE] |-> m_tlast)
    else $error("post-trigger record not marked last");

  // Every record belongs to a capture whose trigger has fired.
  a_fired: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[lat_pkg::TUSER_TRIG])
    else $error("record emitted without a fired trigger");

  // No command is taken while a flush still has records to deliver.
  a_flush_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[lat_pkg::TUSER_PRE] && !m_tlast |-> !s_tready)
    else $error("input ready in the middle of a flush");

endmodule

bind logic_analyzer_trigger_capture_top lat_checker u_lat_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
